FILE: sv/rhis_pkg.sv
// shared types, constants and helpers for the rotor harmonic inflow solver
`timescale 1ns / 1ps
`default_nettype none
package rhis_pkg;

  typedef logic signed [63:0] q64_t;

  localparam q64_t LIM          = 64'sh1000_0000_0000_0000;
  localparam q64_t MAX32        = 64'sd2147483647;
  localparam q64_t MIN32        = -64'sd2147483648;
  localparam q64_t DAMP         = 64'sd161061274;
  localparam q64_t TOL          = 64'sd268435;
  localparam logic signed [31:0] RESET_INFLOW = 32'sd13421773;
  localparam logic [30:0] LIFT_RST = 31'd1530082099;
  localparam logic [28:0] SOL_RST  = 29'd26843546;
  localparam int MAX_ITER_DEF = 64;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic CFG_LIFT = 1'b0;
  localparam logic CFG_SOL  = 1'b1;

  function automatic logic [63:0] mag(input q64_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic q64_t sat60(input q64_t v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic q64_t sat32(input q64_t v);
    if (v > MAX32) return MAX32;
    if (v < MIN32) return MIN32;
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rhis_mulu.sv
// fixed point multiplier built on one 32x32 multiplier over four partial products
`timescale 1ns / 1ps
`default_nettype none
module rhis_mulu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rhis_pkg::q64_t a_i,
  input  wire rhis_pkg::q64_t b_i,
  output logic               done_o,
  output rhis_pkg::q64_t     res_o
);

  logic         busy_q;
  logic [2:0]   cnt_q;
  logic [63:0]  xm_q, ym_q, prod_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [31:0]  opx, opy;
  logic [63:0]  rm;

  always_comb begin
    case (cnt_q)
      3'd0: begin opx = xm_q[31:0];  opy = ym_q[31:0];  end
      3'd1: begin opx = xm_q[31:0];  opy = ym_q[63:32]; end
      3'd2: begin opx = xm_q[63:32]; opy = ym_q[31:0];  end
      3'd3: begin opx = xm_q[63:32]; opy = ym_q[63:32]; end
      default: begin opx = '0; opy = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == 3'd5) busy_q <= 1'b0;
      else cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xm_q  <= rhis_pkg::mag(a_i);
      ym_q  <= rhis_pkg::mag(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) prod_q <= opx * opy;
      case (cnt_q)
        3'd1: acc_q <= acc_q + {64'd0, prod_q};
        3'd2, 3'd3: acc_q <= acc_q + {32'd0, prod_q, 32'd0};
        3'd4: acc_q <= acc_q + {prod_q, 64'd0};
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign rm     = (acc_q[127:88] != '0) ? 64'(rhis_pkg::LIM) : {4'd0, acc_q[87:28]};
  assign res_o  = neg_q ? -rhis_pkg::q64_t'(rm) : rhis_pkg::q64_t'(rm);
  assign done_o = busy_q && (cnt_q == 3'd5);

endmodule
`default_nettype wire

FILE: sv/rhis_divu.sv
// fixed point restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rhis_divu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rhis_pkg::q64_t a_i,
  input  wire rhis_pkg::q64_t b_i,
  output logic               done_o,
  output rhis_pkg::q64_t     res_o
);

  localparam int NBits = 89;

  logic              busy_q;
  logic [6:0]        cnt_q;
  logic [NBits-1:0]  n_q, q_q;
  logic [63:0]       rem_q, ud_q, rs, qm;
  logic              neg_q, ge;
  logic [63:0]       an;

  assign an = rhis_pkg::mag(a_i);
  assign rs = {rem_q[62:0], n_q[NBits-1]};
  assign ge = rs >= ud_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == 7'(NBits)) busy_q <= 1'b0;
      else cnt_q <= cnt_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {an[60:0], 28'd0};
      ud_q  <= rhis_pkg::mag(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q && cnt_q != 7'(NBits)) begin
      rem_q <= ge ? rs - ud_q : rs;
      n_q   <= {n_q[NBits-2:0], 1'b0};
      q_q   <= {q_q[NBits-2:0], ge};
    end
  end

  assign qm     = (q_q > NBits'(rhis_pkg::LIM)) ? 64'(rhis_pkg::LIM) : q_q[63:0];
  assign res_o  = neg_q ? -rhis_pkg::q64_t'(qm) : rhis_pkg::q64_t'(qm);
  assign done_o = busy_q && (cnt_q == 7'(NBits));

endmodule
`default_nettype wire

FILE: sv/rhis_sqrtu.sv
// fixed point square root, normalized then one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rhis_sqrtu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rhis_pkg::q64_t a_i,
  output logic               done_o,
  output rhis_pkg::q64_t     res_o
);

  logic        busy_q;
  logic [63:0] x_q, r_q, b_q, t;
  logic [3:0]  shf_q, shf;
  logic [4:0]  esel;
  logic [63:0] ux;

  assign ux = 64'(a_i);

  always_comb begin
    esel = '0;
    shf  = 4'd14;
    for (int k = 0; k <= 14; k++) begin
      if ((ux >> (62 - 2 * k)) == '0) begin
        esel = 5'(2 * k);
        shf  = 4'(14 - k);
      end
    end
  end

  assign t = r_q + b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && b_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      if (a_i <= 0) begin
        x_q   <= '0;
        b_q   <= '0;
        shf_q <= '0;
      end else begin
        x_q   <= ux << esel;
        b_q   <= 64'd1 << 62;
        shf_q <= shf;
      end
    end else if (busy_q && b_q != '0) begin
      if (x_q >= t) begin
        x_q <= x_q - t;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign res_o  = rhis_pkg::q64_t'(r_q << shf_q);
  assign done_o = busy_q && (b_q == '0);

endmodule
`default_nettype wire

FILE: sv/rotor_harmonic_inflow_solver.sv
// top level: rotor inflow solver with newton sequencer over shared arithmetic units
`timescale 1ns / 1ps
`default_nettype none
// Solves the uniform rotor inflow by a damped Newton iteration started from the
// last result, then the cosine and sine harmonic inflows. One word is taken at a
// time; s_axis_tready is low until the result is written to the output register.
// Each Newton step runs eight multiplications on the shared 32x32 multiplier,
// one square root and one division; an item takes up to MaxIter steps plus
// setup and the harmonic terms. The sequencer runs one unit at a time, so
// the step count sets the latency. status: 0 converged, 1 step limit reached,
// 2 invalid division with the affected outputs forced to zero.
module rotor_harmonic_inflow_solver #(
  parameter int MaxIter = rhis_pkg::MAX_ITER_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [0:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // thrust_coeff, advance_ratio, axial_ratio, cyclic_pitch_cos, cyclic_pitch_sin,
  // flap_cos, flap_sin, roll_rate_norm, pitch_rate_norm
  input  wire logic [287:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // uniform_inflow, inflow_cos, inflow_sin
  output logic [95:0]       m_axis_tdata,
  // status
  output logic [1:0]        m_axis_tuser
);

  localparam int ItW = (MaxIter > 1) ? $clog2(MaxIter) : 1;

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_AS   = 4'd1;
  localparam logic [3:0] P_MU   = 4'd2;
  localparam logic [3:0] P_DD   = 4'd3;
  localparam logic [3:0] P_SQ   = 4'd4;
  localparam logic [3:0] P_LR   = 4'd5;
  localparam logic [3:0] P_NUM  = 4'd6;
  localparam logic [3:0] P_BR   = 4'd7;
  localparam logic [3:0] P_AB   = 4'd8;
  localparam logic [3:0] P_CD   = 4'd9;
  localparam logic [3:0] P_DIV  = 4'd10;
  localparam logic [3:0] P_DMP  = 4'd11;
  localparam logic [3:0] P_HD   = 4'd12;
  localparam logic [3:0] P_C    = 4'd13;
  localparam logic [3:0] P_S    = 4'd14;
  localparam logic [3:0] P_OUT  = 4'd15;

  logic [3:0]      pc_q;
  logic            wait_q;
  logic [ItW-1:0]  it_q;
  logic [30:0]     lift_q;
  logic [28:0]     sol_q;
  logic signed [31:0] prev_q;
  rhis_pkg::q64_t  ct_q, mu_q, mz_q, s1_q, s2_q;
  rhis_pkg::q64_t  as_q, l_q, d_q, big_q, r_q, a_q, num_q, den_q, t_q, lc_q, ls_q;
  logic [1:0]      st_q;
  logic            ov_q;
  logic [31:0]     ol_q, oc_q, os_q;
  logic [1:0]      ost_q;

  rhis_pkg::q64_t  in_f [9];
  rhis_pkg::q64_t  opa, opb, hd, den_n, nl, delta, res, prev_x;
  logic            hd_zero, launch, mul_go, div_go, sq_go;
  logic            mul_done, div_done, sq_done, done;
  rhis_pkg::q64_t  mul_res, div_res, sq_res;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      in_f[k] = {{32{s_axis_tdata[32*k+31]}}, s_axis_tdata[32*k +: 32]};
    end
  end

  assign prev_x  = {{32{prev_q[31]}}, prev_q};
  assign hd      = rhis_pkg::sat60((l_q <<< 4) + as_q);
  assign hd_zero = (l_q == 0) || (hd == 0);

  always_comb begin
    case (pc_q)
      P_AS:    begin opa = {33'd0, lift_q}; opb = {35'd0, sol_q}; end
      P_MU:    begin opa = mu_q;            opb = mu_q;           end
      P_DD:    begin opa = d_q;             opb = d_q;            end
      P_SQ:    begin opa = big_q;           opb = '0;             end
      P_LR:    begin opa = l_q;             opb = r_q;            end
      P_NUM:   begin opa = a_q;             opb = big_q;          end
      P_BR:    begin opa = big_q;           opb = r_q;            end
      P_AB:    begin opa = as_q >>> 2;      opb = big_q;          end
      P_CD:    begin opa = ct_q;            opb = d_q;            end
      P_DIV:   begin opa = num_q;           opb = den_q;          end
      P_DMP:   begin opa = rhis_pkg::DAMP;  opb = t_q;            end
      P_HD:    begin opa = as_q;            opb = hd;             end
      P_C:     begin opa = t_q;             opb = s1_q;           end
      P_S:     begin opa = t_q;             opb = s2_q;           end
      default: begin opa = '0;              opb = '0;             end
    endcase
  end

  assign launch = !wait_q && (pc_q != P_IDLE) && (pc_q != P_OUT) &&
                  !((pc_q == P_HD) && hd_zero);
  assign sq_go  = launch && (pc_q == P_SQ);
  assign div_go = launch && ((pc_q == P_DIV) || (pc_q == P_HD));
  assign mul_go = launch && !sq_go && !div_go;

  rhis_mulu u_mul (
    .clk_i, .rst_ni, .start_i(mul_go), .a_i(opa), .b_i(opb),
    .done_o(mul_done), .res_o(mul_res)
  );

  rhis_divu u_div (
    .clk_i, .rst_ni, .start_i(div_go), .a_i(opa), .b_i(opb),
    .done_o(div_done), .res_o(div_res)
  );

  rhis_sqrtu u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_go), .a_i(opa),
    .done_o(sq_done), .res_o(sq_res)
  );

  assign done = mul_done || div_done || sq_done;
  assign res  = (pc_q == P_SQ) ? sq_res :
                ((pc_q == P_DIV) || (pc_q == P_HD)) ? div_res : mul_res;

  assign den_n = rhis_pkg::sat60(t_q + res);
  assign nl    = rhis_pkg::sat32(l_q + res);
  assign delta = nl - l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= P_IDLE;
      wait_q <= 1'b0;
      it_q   <= '0;
      lift_q <= rhis_pkg::LIFT_RST;
      sol_q  <= rhis_pkg::SOL_RST;
      prev_q <= rhis_pkg::RESET_INFLOW;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i[0])
          rhis_pkg::CFG_LIFT: lift_q <= cfg_data_i[30:0];
          rhis_pkg::CFG_SOL:  sol_q  <= cfg_data_i[28:0];
          default: ;
        endcase
      end
      if (m_axis_tready && pc_q != P_OUT) ov_q <= 1'b0;
      case (pc_q)
        P_IDLE: begin
          if (s_axis_tvalid) begin
            it_q <= '0;
            pc_q <= P_AS;
          end
        end
        P_OUT: begin
          if (!ov_q || m_axis_tready) begin
            ov_q   <= 1'b1;
            prev_q <= l_q[31:0];
            pc_q   <= P_IDLE;
          end
        end
        default: begin
          if (!wait_q) begin
            if (pc_q == P_HD && hd_zero) pc_q <= P_OUT;
            else wait_q <= 1'b1;
          end else if (done) begin
            wait_q <= 1'b0;
            case (pc_q)
              P_AS:  pc_q <= P_MU;
              P_MU:  pc_q <= P_DD;
              P_DD:  pc_q <= P_SQ;
              P_SQ:  pc_q <= P_LR;
              P_LR:  pc_q <= P_NUM;
              P_NUM: pc_q <= P_BR;
              P_BR:  pc_q <= P_AB;
              P_AB:  pc_q <= P_CD;
              P_CD:  pc_q <= (den_n == 0) ? P_OUT : P_DIV;
              P_DIV: pc_q <= P_DMP;
              P_DMP: begin
                if ((delta <= rhis_pkg::TOL && delta >= -rhis_pkg::TOL) ||
                    it_q == ItW'(MaxIter - 1)) begin
                  pc_q <= P_HD;
                end else begin
                  it_q <= it_q + 1'b1;
                  pc_q <= P_MU;
                end
              end
              P_HD:  pc_q <= P_C;
              P_C:   pc_q <= P_S;
              P_S:   pc_q <= P_OUT;
              default: pc_q <= P_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (pc_q)
      P_IDLE: begin
        if (s_axis_tvalid) begin
          ct_q <= in_f[0];
          mu_q <= in_f[1];
          mz_q <= in_f[2];
          s1_q <= in_f[3] - in_f[6] + in_f[8];
          s2_q <= in_f[4] + in_f[5] + in_f[7];
          l_q  <= prev_x;
          d_q  <= rhis_pkg::sat60(prev_x - in_f[2]);
          lc_q <= '0;
          ls_q <= '0;
          st_q <= rhis_pkg::ST_LIMIT;
        end
      end
      P_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ol_q  <= l_q[31:0];
          oc_q  <= lc_q[31:0];
          os_q  <= ls_q[31:0];
          ost_q <= st_q;
        end
      end
      default: begin
        if (!wait_q && pc_q == P_HD && hd_zero) begin
          st_q <= rhis_pkg::ST_BAD;
        end else if (wait_q && done) begin
          case (pc_q)
            P_AS:  as_q  <= res;
            P_MU:  t_q   <= res;
            P_DD:  big_q <= rhis_pkg::sat60(t_q + res);
            P_SQ:  r_q   <= res;
            P_LR:  a_q   <= rhis_pkg::sat60((res <<< 1) - ct_q);
            P_NUM: num_q <= res;
            P_BR:  t_q   <= res <<< 1;
            P_AB:  t_q   <= t_q + res;
            P_CD: begin
              den_q <= den_n;
              if (den_n == 0) begin
                l_q  <= '0;
                st_q <= rhis_pkg::ST_BAD;
              end
            end
            P_DIV: t_q <= -res;
            P_DMP: begin
              l_q <= nl;
              d_q <= rhis_pkg::sat60(nl - mz_q);
              if (delta <= rhis_pkg::TOL && delta >= -rhis_pkg::TOL) begin
                st_q <= rhis_pkg::ST_CONV;
              end
            end
            P_HD:  t_q  <= res;
            P_C:   lc_q <= rhis_pkg::sat32(res);
            P_S:   ls_q <= rhis_pkg::sat32(res);
            default: ;
          endcase
        end
      end
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (pc_q == P_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {os_q, oc_q, ol_q};
  assign m_axis_tuser  = ost_q;

endmodule
`default_nettype wire

FILE: sv/rhis_checker.sv
// port level checks for the rotor inflow solver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module rhis_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while solving");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a solve in progress");

endmodule

bind rotor_harmonic_inflow_solver rhis_checker u_rhis_checker (.*);
`default_nettype wire
